@@ hw/rtl/salc_pkg.sv @@
`timescale 1ns / 1ps
// Shared widths, constants and controller/datapath interface types for the LRU tag model.
package salc_pkg;

	localparam int ADDR_W     = 64;
	localparam int BYTES_W    = 11;
	localparam int CFG_W      = 4;
	localparam int OUT_CNT_W  = 9;
	localparam int LOG2_MIN   = 2;
	localparam int LOG2_MAX   = 12;
	localparam logic [CFG_W-1:0] LOG2_RESET = 4'd6;
	// Line number width at the smallest line size.
	localparam int LINE_W     = ADDR_W - LOG2_MIN;
	// Offset plus length stays below 2^13 for every legal access size.
	localparam int CNT_W      = 13;
	// Set-index reduction: weighted chunk sum, reciprocal quotient, remainder.
	localparam int RED_SUM_STEP = 0;
	localparam int RED_QUO_STEP = 1;
	localparam int RED_REM_STEP = 2;
	localparam int MOD_STEPS    = 3;
	localparam int MOD_CNT_W    = 2;
	localparam int IN_DATA_W  = 80;
	localparam int OUT_DATA_W = 24;

	typedef struct packed {
		logic accept;    // capture a new access
		logic mod_step;  // one step of the set-index reduction
		logic rd_en;     // read the set row
		logic update;    // compare, write back the set row, advance to next line
		logic load_out;  // load the result register
		logic clr_wr;    // write one invalid row during the clearing pass
	} salc_cmd_t;

	typedef struct packed {
		logic set_direct; // set index is ready at capture
		logic set_ready;  // set-index reduction finished
		logic last_line;  // the line under way is the last of the access
		logic clr_last;   // clearing pass is at the last row
	} salc_status_t;

endpackage

@@ hw/rtl/set_assoc_lru_cache_tag_model.sv @@
`timescale 1ns / 1ps
// Top level of the set-associative LRU cache tag model.
//
//  channel   direction  handshake              payload
//  cfg       in         cfg_valid / cfg_ready  cfg_data: line_bytes_log2
//  s         in         s_tvalid / s_tready    s_tdata: byte_address, access_bytes
//  m         out        m_tvalid / m_tready    m_tdata: lines_touched, miss_count
//
// An access does one RAM read and one compare/write-back per touched line; a set
// count that is not a power of two adds the set-index reduction before the first
// read. The result register is loaded in the last compare cycle if the output is
// free, else from a wait state, so a stalled output holds the next access only
// at its end. After reset a clearing pass writes NUM_SETS rows, one per cycle,
// before the first access is taken; configuration writes are taken at any time.
module set_assoc_lru_cache_tag_model import salc_pkg::*; #(
	parameter int NUM_SETS         = 64,
	parameter int NUM_WAYS         = 4,
	parameter int MAX_ACCESS_BYTES = 1024
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_W-1:0]      cfg_data,   // [3:0] line_bytes_log2
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,    // [63:0] byte_address, [74:64] access_bytes
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata     // [8:0] lines_touched, [17:9] miss_count
);

	salc_cmd_t            cmd;
	salc_status_t         status;
	logic [OUT_CNT_W-1:0] out_lines;
	logic [OUT_CNT_W-1:0] out_miss;

	assign cfg_ready = 1'b1;

	salc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.status   (status),
		.cmd      (cmd)
	);

	salc_dp #(
		.NUM_SETS         (NUM_SETS),
		.NUM_WAYS         (NUM_WAYS),
		.MAX_ACCESS_BYTES (MAX_ACCESS_BYTES)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_data  (cfg_data),
		.in_addr   (s_tdata[ADDR_W-1:0]),
		.in_bytes  (s_tdata[ADDR_W +: BYTES_W]),
		.cmd       (cmd),
		.status    (status),
		.out_lines (out_lines),
		.out_miss  (out_miss)
	);

	assign m_tdata = {{(OUT_DATA_W - 2*OUT_CNT_W){1'b0}}, out_miss, out_lines};

endmodule

@@ hw/rtl/salc_ram.sv @@
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
module salc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                   clk,
	input  logic                                   wr_en,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  logic [WIDTH-1:0]                       wr_data,
	input  logic                                   rd_en,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic [WIDTH-1:0]                       rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

@@ hw/rtl/salc_dp.sv @@
`timescale 1ns / 1ps
// Datapath: line split, set-index reduction, tag RAM, way compare, LRU reorder and counts.
module salc_dp import salc_pkg::*; #(
	parameter int NUM_SETS         = 64,
	parameter int NUM_WAYS         = 4,
	parameter int MAX_ACCESS_BYTES = 1024
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	input  logic [CFG_W-1:0]     cfg_data,
	input  logic [ADDR_W-1:0]    in_addr,
	input  logic [BYTES_W-1:0]   in_bytes,
	input  salc_cmd_t            cmd,
	output salc_status_t         status,
	output logic [OUT_CNT_W-1:0] out_lines,
	output logic [OUT_CNT_W-1:0] out_miss
);

	localparam int  SET_W     = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
	localparam int  WAY_W     = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
	localparam int  ENT_W     = LINE_W + 1;
	localparam int  ROW_W     = NUM_WAYS * ENT_W;
	localparam bit  SETS_POW2 = (NUM_SETS & (NUM_SETS - 1)) == 0;

	// Line number split into 16-bit chunks (the top one 14 bits wide), each weighted by 2^(16*i) mod NUM_SETS.
	localparam int  RED_W     = 18 + SET_W;
	localparam int  RED_S     = RED_W + SET_W;
	localparam int  QUO_W     = RED_W - SET_W + 1;
	localparam int  PROD_W    = 2 * RED_W + 2;
	localparam logic [63:0] SETS64  = 64'(NUM_SETS);
	localparam logic [63:0] RECIP64 = ((64'd1 << RED_S) + SETS64 - 64'd1) / SETS64;
	localparam logic [RED_W+1:0] RECIP = (RED_W + 2)'(RECIP64);
	localparam logic [SET_W-1:0] WGT0  = SET_W'(64'd1 % SETS64);
	localparam logic [SET_W-1:0] WGT1  = SET_W'((64'd1 << 16) % SETS64);
	localparam logic [SET_W-1:0] WGT2  = SET_W'((64'd1 << 32) % SETS64);
	localparam logic [SET_W-1:0] WGT3  = SET_W'((64'd1 << 48) % SETS64);

	logic [CFG_W-1:0]     cfg_q;
	logic [SET_W-1:0]     clr_cnt_q;
	logic [LINE_W-1:0]    line_q;
	logic [SET_W-1:0]     set_q;
	logic [RED_W-1:0]     red_sum_q;
	logic [QUO_W-1:0]     red_quo_q;
	logic [MOD_CNT_W-1:0] mod_cnt_q;
	logic [CNT_W-1:0]     remain_q;
	logic [CNT_W-1:0]     lines_q;
	logic [CNT_W-1:0]     miss_q;
	logic [OUT_CNT_W-1:0] out_lines_q;
	logic [OUT_CNT_W-1:0] out_miss_q;

	logic [CFG_W-1:0]     sh;
	logic [CNT_W-1:0]     size_ext;
	logic [CNT_W-1:0]     size_eff;
	logic [CNT_W-1:0]     off_mask;
	logic [CNT_W-1:0]     span;
	logic [CNT_W-1:0]     n_lines;
	logic [ADDR_W-1:0]    first64;
	logic [LINE_W-1:0]    first_line;
	logic [SET_W-1:0]     first_set;
	logic [LINE_W-1:0]    lmask;
	logic [RED_W-1:0]     red_sum;
	logic [PROD_W-1:0]    red_prod;
	logic [RED_W-1:0]     red_rem;
	logic [LINE_W-1:0]    next_line;
	logic [SET_W-1:0]     next_set;

	logic [ROW_W-1:0]     rd_row;
	logic [ROW_W-1:0]     new_row;
	logic [NUM_WAYS-1:0]  hit_vec;
	logic                 hit;
	logic [WAY_W-1:0]     hit_way;
	logic [WAY_W-1:0]     stop_way;
	logic [CNT_W-1:0]     miss_next;

	logic                 ram_wr_en;
	logic [SET_W-1:0]     ram_wr_addr;
	logic [ROW_W-1:0]     ram_wr_data;

	// Clamp the line size and the length, and split the access into a first line and a line count.
	always_comb begin
		if (cfg_q < CFG_W'(LOG2_MIN)) begin
			sh = CFG_W'(LOG2_MIN);
		end else if (cfg_q > CFG_W'(LOG2_MAX)) begin
			sh = CFG_W'(LOG2_MAX);
		end else begin
			sh = cfg_q;
		end
		size_ext = {{(CNT_W - BYTES_W){1'b0}}, in_bytes};
		if (size_ext == '0) begin
			size_eff = CNT_W'(1);
		end else if (size_ext > CNT_W'(MAX_ACCESS_BYTES)) begin
			size_eff = CNT_W'(MAX_ACCESS_BYTES);
		end else begin
			size_eff = size_ext;
		end
		off_mask   = (CNT_W'(1) << sh) - CNT_W'(1);
		span       = ({{(CNT_W - LOG2_MAX){1'b0}}, in_addr[LOG2_MAX-1:0]} & off_mask)
			+ size_eff - CNT_W'(1);
		n_lines    = (span >> sh) + CNT_W'(1);
		first64    = in_addr >> sh;
		first_line = first64[LINE_W-1:0];
		first_set  = (NUM_SETS == 1) ? '0 : first_line[SET_W-1:0];
		lmask      = {LINE_W{1'b1}} >> (sh - CFG_W'(LOG2_MIN));
	end

	// Reduce the line number mod NUM_SETS: fold the chunks, then divide by reciprocal.
	always_comb begin
		red_sum  = RED_W'(line_q[15:0]) * RED_W'(WGT0)
			+ RED_W'(line_q[31:16]) * RED_W'(WGT1)
			+ RED_W'(line_q[47:32]) * RED_W'(WGT2)
			+ RED_W'(line_q[LINE_W-1:48]) * RED_W'(WGT3);
		red_prod = PROD_W'(red_sum_q) * PROD_W'(RECIP);
		red_rem  = red_sum_q - RED_W'(red_quo_q) * RED_W'(NUM_SETS);
	end

	// Step to the next line; the set index restarts at zero where the line number wraps.
	always_comb begin
		if (line_q == lmask) begin
			next_line = '0;
			next_set  = '0;
		end else begin
			next_line = line_q + LINE_W'(1);
			next_set  = (set_q == SET_W'(NUM_SETS - 1)) ? '0 : set_q + SET_W'(1);
		end
	end

	// Way compare and LRU reorder. Full line numbers are stored; within one set
	// equal lines mean equal tags.
	always_comb begin
		for (int i = 0; i < NUM_WAYS; i++) begin
			hit_vec[i] = rd_row[i*ENT_W + LINE_W] && (rd_row[i*ENT_W +: LINE_W] == line_q);
		end
		hit     = |hit_vec;
		hit_way = '0;
		for (int i = NUM_WAYS - 1; i >= 0; i--) begin
			if (hit_vec[i]) begin
				hit_way = WAY_W'(i);
			end
		end
		stop_way = hit ? hit_way : WAY_W'(NUM_WAYS - 1);
		new_row  = rd_row;
		new_row[0 +: ENT_W] = {1'b1, line_q};
		for (int j = 1; j < NUM_WAYS; j++) begin
			if (WAY_W'(j) <= stop_way) begin
				new_row[j*ENT_W +: ENT_W] = rd_row[(j-1)*ENT_W +: ENT_W];
			end
		end
		miss_next = (cmd.update && !hit) ? miss_q + CNT_W'(1) : miss_q;
	end

	always_comb begin
		ram_wr_en   = cmd.clr_wr || cmd.update;
		ram_wr_addr = cmd.clr_wr ? clr_cnt_q : set_q;
		ram_wr_data = cmd.clr_wr ? '0 : new_row;
	end

	salc_ram #(
		.WIDTH (ROW_W),
		.DEPTH (NUM_SETS)
	) u_tag_ram (
		.clk     (clk),
		.wr_en   (ram_wr_en),
		.wr_addr (ram_wr_addr),
		.wr_data (ram_wr_data),
		.rd_en   (cmd.rd_en),
		.rd_addr (set_q),
		.rd_data (rd_row)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q     <= LOG2_RESET;
			clr_cnt_q <= '0;
		end else begin
			if (cfg_valid) begin
				cfg_q <= cfg_data;
			end
			if (cmd.clr_wr) begin
				clr_cnt_q <= clr_cnt_q + SET_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			line_q    <= first_line;
			mod_cnt_q <= '0;
			set_q     <= SETS_POW2 ? first_set : '0;
			remain_q  <= n_lines;
			lines_q   <= n_lines;
			miss_q    <= '0;
		end else if (cmd.mod_step) begin
			if (mod_cnt_q == MOD_CNT_W'(RED_SUM_STEP)) begin
				red_sum_q <= red_sum;
			end else if (mod_cnt_q == MOD_CNT_W'(RED_QUO_STEP)) begin
				red_quo_q <= red_prod[RED_S +: QUO_W];
			end else begin
				set_q <= red_rem[SET_W-1:0];
			end
			mod_cnt_q <= mod_cnt_q + MOD_CNT_W'(1);
		end else if (cmd.update) begin
			line_q   <= next_line;
			set_q    <= next_set;
			remain_q <= remain_q - CNT_W'(1);
			miss_q   <= miss_next;
		end
		if (cmd.load_out) begin
			out_lines_q <= lines_q[OUT_CNT_W-1:0];
			out_miss_q  <= miss_next[OUT_CNT_W-1:0];
		end
	end

	always_comb begin
		status.set_direct = SETS_POW2;
		status.set_ready  = (mod_cnt_q == MOD_CNT_W'(MOD_STEPS));
		status.last_line  = (remain_q == CNT_W'(1));
		status.clr_last   = (clr_cnt_q == SET_W'(NUM_SETS - 1));
	end

	assign out_lines = out_lines_q;
	assign out_miss  = out_miss_q;

endmodule

@@ hw/rtl/salc_ctrl.sv @@
`timescale 1ns / 1ps
// Controller: clearing pass, per-access sequencing of line lookups and result handoff.
module salc_ctrl import salc_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	output logic         m_tvalid,
	input  logic         m_tready,
	input  salc_status_t status,
	output salc_cmd_t    cmd
);

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_MOD,
		ST_READ,
		ST_CMP,
		ST_DONE
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   out_free;

	assign out_free = !out_valid_q || m_tready;
	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = out_valid_q;

	always_comb begin
		cmd = '0;
		case (state_q)
			ST_CLEAR: cmd.clr_wr   = 1'b1;
			ST_IDLE:  cmd.accept   = s_tvalid;
			ST_MOD:   cmd.mod_step = !status.set_ready;
			ST_READ:  cmd.rd_en    = 1'b1;
			ST_CMP: begin
				cmd.update   = 1'b1;
				cmd.load_out = status.last_line && out_free;
			end
			ST_DONE:  cmd.load_out = out_free;
			default:  cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_CLEAR: begin
					if (status.clr_last) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (s_tvalid) begin
						state_q <= status.set_direct ? ST_READ : ST_MOD;
					end
				end
				ST_MOD: begin
					if (status.set_ready) begin
						state_q <= ST_READ;
					end
				end
				ST_READ: state_q <= ST_CMP;
				ST_CMP: begin
					if (!status.last_line) begin
						state_q <= ST_READ;
					end else if (out_free) begin
						state_q <= ST_IDLE;
					end else begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// A set row is written back only right after it was read.
	a_update_after_read: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.update |-> $past(cmd.rd_en))
		else $error("row write-back without preceding read");

	// A pending result is never overwritten.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> (!out_valid_q || m_tready))
		else $error("result register overwritten");

	// One access at a time: no second transaction right after one is taken.
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("input taken while an access is under way");

	// The reduction runs only when the set count is not a power of two.
	a_mod_only_when_needed: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.mod_step |-> !status.set_direct)
		else $error("set-index reduction with power-of-two set count");

endmodule

@@ verif/set_assoc_lru_cache_tag_model_tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the set-associative LRU cache tag model.
module set_assoc_lru_cache_tag_model_tb;
	import salc_pkg::*;

	localparam int NUM_SETS         = 64;
	localparam int NUM_WAYS         = 4;
	localparam int MAX_ACCESS_BYTES = 1024;
	localparam int CYCLE_LIMIT      = 2000000;
	// Longest access: 257 lines, each with one read and one compare.
	localparam int SETTLE_CYCLES    = 600;
	localparam int RANDOM_PHASES    = 9;
	localparam int PHASE_ITEMS      = 61;

	typedef struct packed {
		logic [OUT_CNT_W-1:0] lines;
		logic [OUT_CNT_W-1:0] misses;
	} access_counts_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_W-1:0]      cfg_data = '0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata = '0;   // [63:0] byte_address, [74:64] access_bytes
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;        // [8:0] lines_touched, [17:9] miss_count

	// Local copy of the tag store, LRU order per set with slot 0 as MRU.
	logic [ADDR_W-1:0] lru_tag   [NUM_SETS][NUM_WAYS];
	logic              lru_valid [NUM_SETS][NUM_WAYS];
	logic [CFG_W-1:0]  line_log2_shadow = LOG2_RESET;

	access_counts_t expected_counts[$];
	int unsigned    error_count = 0;
	int unsigned    result_index = 0;
	int unsigned    cycle_count = 0;
	int unsigned    stall_left = 0;
	bit             quiet = 1'b0;

	set_assoc_lru_cache_tag_model #(
		.NUM_SETS(NUM_SETS),
		.NUM_WAYS(NUM_WAYS),
		.MAX_ACCESS_BYTES(MAX_ACCESS_BYTES)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		for (int s = 0; s < NUM_SETS; s++) begin
			for (int w = 0; w < NUM_WAYS; w++) begin
				lru_tag[s][w]   = '0;
				lru_valid[s][w] = 1'b0;
			end
		end
	end

	// Mostly short idle spans, now and then a long one.
	function automatic int unsigned pick_idle();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 40)
			return 0;
		else if (r < 80)
			return $urandom_range(1, 3);
		else if (r < 95)
			return $urandom_range(4, 12);
		return $urandom_range(20, 80);
	endfunction

	task automatic flag_error(input string msg);
		error_count++;
		$display("[%0t] mismatch: %s", $time, msg);
	endtask

	// Look up one line; returns 1 on a miss.
	function automatic logic touch_line(input logic [ADDR_W-1:0] line);
		int unsigned       set_idx;
		logic [ADDR_W-1:0] tag;
		int                hit_way;
		int                j;
		set_idx = 32'(line % ADDR_W'(NUM_SETS));
		tag     = line / NUM_SETS;
		hit_way = NUM_WAYS;
		for (int i = 0; i < NUM_WAYS; i++) begin
			if (hit_way == NUM_WAYS && lru_valid[set_idx][i] && lru_tag[set_idx][i] == tag)
				hit_way = i;
		end
		// A miss overwrites the LRU slot; invalid entries shift like valid ones.
		j = (hit_way < NUM_WAYS) ? hit_way : NUM_WAYS - 1;
		while (j > 0) begin
			lru_tag[set_idx][j]   = lru_tag[set_idx][j-1];
			lru_valid[set_idx][j] = lru_valid[set_idx][j-1];
			j--;
		end
		lru_tag[set_idx][0]   = tag;
		lru_valid[set_idx][0] = 1'b1;
		return hit_way == NUM_WAYS;
	endfunction

	function automatic access_counts_t predict_access(input logic [ADDR_W-1:0] addr,
			input logic [BYTES_W-1:0] bytes);
		int unsigned       sh;
		logic [ADDR_W-1:0] size;
		logic [ADDR_W-1:0] lmask;
		logic [ADDR_W-1:0] first_line;
		logic [ADDR_W-1:0] last_line;
		logic [ADDR_W-1:0] n_lines;
		int unsigned       misses;
		access_counts_t    res;
		sh = line_log2_shadow;
		if (sh < LOG2_MIN)
			sh = LOG2_MIN;
		if (sh > LOG2_MAX)
			sh = LOG2_MAX;
		size = ADDR_W'(bytes);
		if (size == 0)
			size = 1;
		if (size > MAX_ACCESS_BYTES)
			size = MAX_ACCESS_BYTES;
		lmask      = {ADDR_W{1'b1}} >> sh;
		first_line = addr >> sh;
		// Wraps past the top of the address space back to line 0.
		last_line  = (addr + (size - 1)) >> sh;
		n_lines    = ((last_line - first_line) & lmask) + 1;
		misses     = 0;
		for (logic [ADDR_W-1:0] k = 0; k < n_lines; k++)
			misses += touch_line((first_line + k) & lmask);
		res.lines  = n_lines[OUT_CNT_W-1:0];
		res.misses = OUT_CNT_W'(misses);
		return res;
	endfunction

	task automatic send_access(input logic [ADDR_W-1:0] addr, input logic [BYTES_W-1:0] bytes);
		int unsigned gap;
		gap = quiet ? 0 : pick_idle();
		@(negedge clk);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {{(IN_DATA_W - ADDR_W - BYTES_W){1'b0}}, bytes, addr};
		do @(posedge clk); while (!s_tready);
		expected_counts.push_back(predict_access(addr, bytes));
	endtask

	// Hold the sender off until every outstanding result has arrived.
	task automatic wait_results_done();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (expected_counts.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_line_log2(input logic [CFG_W-1:0] value);
		wait_results_done();
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		line_log2_shadow = value;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic test_reset_defaults();
		send_access(64'h0, 11'd1);
		send_access(64'h0, 11'd0);                        // zero length counts as one byte
		send_access(64'd63, 11'd2);                       // straddles two lines
		send_access(64'h0, 11'd2047);                     // saturates to the maximum length
		send_access(64'hFFFF_FFFF_FFFF_FFFF, 11'd1024);   // wraps past the top
		send_access(64'hFFFF_FFFF_FFFF_FFC0, 11'd1025);
		send_access(64'h8000_0000_0000_0000, 11'd1024);
	endtask

	task automatic test_lru_replacement();
		logic [51:0] tags [5];
		tags[0] = 52'h0;
		tags[1] = 52'hF_FFFF_FFFF_FFFF;
		tags[2] = 52'h5_5555_5555_5555;
		tags[3] = 52'hA_AAAA_AAAA_AAAA;
		tags[4] = 52'h1;
		write_line_log2(LOG2_RESET);
		// Fill one set, refresh the oldest, then force evictions.
		for (int i = 0; i < 4; i++)
			send_access({tags[i], 6'd5, 6'd0}, 11'd1);
		send_access({tags[0], 6'd5, 6'd0}, 11'd1);
		send_access({tags[4], 6'd5, 6'd0}, 11'd1);
		send_access({tags[1], 6'd5, 6'd0}, 11'd1);
		send_access({tags[3], 6'd5, 6'd0}, 11'd1);
	endtask

	task automatic test_line_size_limits();
		write_line_log2(4'd0);                   // clamps to the smallest line
		send_access(64'd2, 11'd1024);            // touches the most lines
		send_access(64'd0, 11'd4);
		write_line_log2(4'd15);                  // clamps to the largest line
		send_access(64'd4095, 11'd1024);
		send_access(64'd0, 11'd1);
		write_line_log2(4'd7);                   // stored tags compared under new size
		send_access(64'd0, 11'd128);
		send_access(64'h0000_0000_0004_0000, 11'd256);
	endtask

	task automatic test_random_traffic();
		logic [ADDR_W-1:0]  pool [8];
		logic [ADDR_W-1:0]  addr;
		logic [BYTES_W-1:0] bytes;
		logic [CFG_W-1:0]   setting;
		int unsigned        sh;
		int unsigned        r;
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			if (p == 0)
				setting = CFG_W'(LOG2_MIN);
			else if (p == 1)
				setting = CFG_W'(LOG2_MAX);
			else
				setting = CFG_W'($urandom_range(0, 15));
			write_line_log2(setting);
			sh = (setting < LOG2_MIN) ? LOG2_MIN : (setting > LOG2_MAX) ? LOG2_MAX : setting;
			// Six of the eight pool entries land in one set with distinct tags to force evictions.
			pool[0] = {$urandom, $urandom};
			for (int i = 1; i < 8; i++) begin
				if (i < 6)
					pool[i] = pool[0] + (ADDR_W'(i) << (sh + 6));
				else
					pool[i] = {$urandom, $urandom};
			end
			quiet = (p == 4);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if (p == 2 && n == 30)
					wait_results_done();
				r = $urandom_range(0, 99);
				if (r < 10)
					addr = {$urandom, $urandom};
				else
					addr = pool[$urandom_range(0, 7)] + $urandom_range(0, 4096);
				r = $urandom_range(0, 99);
				if (r < 60)
					bytes = BYTES_W'($urandom_range(1, 16));
				else if (r < 85)
					bytes = BYTES_W'($urandom_range(1, 256));
				else if (r < 92)
					bytes = BYTES_W'($urandom_range(257, 1024));
				else if (r < 97)
					bytes = BYTES_W'($urandom_range(1025, 2047));
				else
					bytes = '0;
				send_access(addr, bytes);
			end
			quiet = 1'b0;
		end
	endtask

	always @(negedge clk) begin
		if (quiet) begin
			m_tready   <= 1'b1;
			stall_left <= 0;
		end else if (stall_left > 0) begin
			m_tready   <= 1'b0;
			stall_left <= stall_left - 1;
		end else if ($urandom_range(0, 3) == 0) begin
			m_tready   <= 1'b0;
			stall_left <= pick_idle();
		end else begin
			m_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		access_counts_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_counts.size() == 0) begin
				flag_error($sformatf("result %0d arrived with nothing expected", result_index));
			end else begin
				want = expected_counts.pop_front();
				if (m_tdata[8:0] !== want.lines)
					flag_error($sformatf("result %0d lines_touched got %0d want %0d",
						result_index, m_tdata[8:0], want.lines));
				if (m_tdata[17:9] !== want.misses)
					flag_error($sformatf("result %0d miss_count got %0d want %0d",
						result_index, m_tdata[17:9], want.misses));
			end
			result_index++;
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	initial begin
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_reset_defaults();
		test_lru_replacement();
		test_line_size_limits();
		test_random_traffic();
		wait_results_done();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

@@ set_assoc_lru_cache_tag_model.f @@
hw/rtl/salc_pkg.sv
hw/rtl/salc_ram.sv
hw/rtl/salc_dp.sv
hw/rtl/salc_ctrl.sv
hw/rtl/set_assoc_lru_cache_tag_model.sv
verif/set_assoc_lru_cache_tag_model_tb.sv
